>>> rtl/core/lpwbe_pkg.sv
package lpwbe_pkg;

	localparam int unsigned CFG_W         = 16;
	localparam int unsigned CFG_INDEX_W   = 2;
	localparam int unsigned DUR_W         = 20;
	localparam int unsigned NBITS_W       = 4;
	localparam int unsigned BYTE_BITS     = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_EXTRA_TICKS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LIMIT_BITS  = 2'd2;

	localparam logic [CFG_W-1:0] UNIT_TICKS_RST        = 16'd100;
	localparam logic [CFG_W-1:0] START_EXTRA_TICKS_RST = 16'd10;
	localparam logic [CFG_W-1:0] FRAME_LIMIT_BITS_RST  = 16'd65535;

	typedef struct packed {
		logic [CFG_W-1:0] unit_ticks;
		logic [CFG_W-1:0] start_extra_ticks;
		logic [CFG_W-1:0] frame_limit_bits;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic             led_level;
		logic [DUR_W-1:0] duration_ticks;
		logic             last_segment;
	} seg_item_t;

	// one classified byte: what the back end has to play out
	typedef struct packed {
		logic [7:0]         data_byte;
		logic               start;
		logic [NBITS_W-1:0] nbits;
		logic               last;
	} cmd_t;

endpackage

>>> rtl/core/lpwbe_stream_if.sv
interface lpwbe_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lpwbe_front.sv
module lpwbe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  lpwbe_pkg::cfg_t     cfg,
	lpwbe_stream_if.sink        bytes,
	input  logic                full,
	output logic                push,
	output lpwbe_pkg::cmd_t     push_cmd
);

	logic                                in_message_q;
	logic [lpwbe_pkg::CFG_W-1:0]         bits_sent_q;
	logic [lpwbe_pkg::CFG_W-1:0]         remaining;
	logic                                has_room;
	logic [lpwbe_pkg::NBITS_W-1:0]       nbits;
	logic                                accept;

	assign bytes.ready = !full;
	assign accept      = bytes.valid && !full;

	assign has_room  = bits_sent_q < cfg.frame_limit_bits;
	assign remaining = cfg.frame_limit_bits - bits_sent_q;

	always_comb begin
		if (!has_room) begin
			nbits = '0;
		end else if (remaining >= lpwbe_pkg::CFG_W'(lpwbe_pkg::BYTE_BITS)) begin
			nbits = lpwbe_pkg::NBITS_W'(lpwbe_pkg::BYTE_BITS);
		end else begin
			nbits = remaining[lpwbe_pkg::NBITS_W-1:0];
		end
	end

	always_comb begin
		push_cmd.data_byte = bytes.data.data_byte;
		push_cmd.start     = !in_message_q;
		push_cmd.nbits     = nbits;
		push_cmd.last      = bytes.data.last_byte;
	end

	// a middle byte with every bit past the frame limit produces nothing
	assign push = accept && (!in_message_q || (nbits != '0) || bytes.data.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
			bits_sent_q  <= '0;
		end else if (accept) begin
			if (bytes.data.last_byte) begin
				in_message_q <= 1'b0;
				bits_sent_q  <= '0;
			end else begin
				in_message_q <= 1'b1;
				// never passes the frame limit, so no saturation needed
				bits_sent_q  <= bits_sent_q + lpwbe_pkg::CFG_W'(nbits);
			end
		end
	end

endmodule

>>> rtl/core/lpwbe_cmd_queue.sv
module lpwbe_cmd_queue #(
	parameter int unsigned DEPTH = lpwbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpwbe_pkg::cmd_t push_cmd,
	input  logic            pop,
	output lpwbe_pkg::cmd_t head,
	output logic            full,
	output logic            empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	lpwbe_pkg::cmd_t entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/lpwbe_back.sv
module lpwbe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lpwbe_pkg::cfg_t cfg,
	input  lpwbe_pkg::cmd_t head,
	input  logic            empty,
	output logic            pop,
	lpwbe_stream_if.source  segments
);

	localparam logic [2:0] PH_FIRST  = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_BIT_LO = 3'd2;
	localparam logic [2:0] PH_BIT_HI = 3'd3;
	localparam logic [2:0] PH_END_LO = 3'd4;
	localparam logic [2:0] PH_END_HI = 3'd5;
	localparam logic [2:0] PH_HOLD   = 3'd6;

	localparam int unsigned DW = lpwbe_pkg::DUR_W;

	logic [2:0]             phase_q;
	logic [2:0]             cur_phase;
	logic [2:0]             nxt_phase;
	logic [2:0]             bit_cnt_q;
	logic                   done;
	logic                   fire;
	logic                   out_valid_q;
	lpwbe_pkg::seg_item_t   out_q;
	logic                   seg_level;
	logic [DW-1:0]          seg_dur;
	logic [DW-1:0]          unit_d;
	logic [DW-1:0]          dur_start;
	logic [DW-1:0]          dur_two;
	logic [DW-1:0]          dur_nine;
	logic                   cur_bit;
	logic                   more_bits;
	logic [2:0]             after_bits;

	assign unit_d    = DW'(cfg.unit_ticks);
	assign dur_start = unit_d + DW'(cfg.start_extra_ticks);
	assign dur_two   = {unit_d[DW-2:0], 1'b0};
	assign dur_nine  = {unit_d[DW-4:0], 3'b000} + unit_d;

	// MSB first
	assign cur_bit   = head.data_byte[3'd7 - bit_cnt_q];
	assign more_bits = ({1'b0, bit_cnt_q} + 4'd1) < head.nbits;
	assign after_bits = head.last ? PH_END_LO : PH_FIRST;

	always_comb begin
		if (phase_q != PH_FIRST) begin
			cur_phase = phase_q;
		end else if (head.start) begin
			cur_phase = PH_START;
		end else if (head.nbits != '0) begin
			cur_phase = PH_BIT_LO;
		end else begin
			cur_phase = PH_END_LO;
		end
	end

	always_comb begin
		seg_level = 1'b0;
		seg_dur   = unit_d;
		nxt_phase = PH_FIRST;
		case (cur_phase)
			PH_START: begin
				seg_level = 1'b1;
				seg_dur   = dur_start;
				nxt_phase = (head.nbits != '0) ? PH_BIT_LO : after_bits;
			end
			PH_BIT_LO: begin
				nxt_phase = PH_BIT_HI;
			end
			PH_BIT_HI: begin
				seg_level = 1'b1;
				seg_dur   = cur_bit ? dur_two : unit_d;
				nxt_phase = more_bits ? PH_BIT_LO : after_bits;
			end
			PH_END_LO: begin
				nxt_phase = PH_END_HI;
			end
			PH_END_HI: begin
				seg_level = 1'b1;
				seg_dur   = dur_nine;
				nxt_phase = PH_HOLD;
			end
			PH_HOLD: begin
				seg_dur   = '0;
				nxt_phase = PH_FIRST;
			end
			default: begin
				nxt_phase = PH_FIRST;
			end
		endcase
	end

	assign done = nxt_phase == PH_FIRST;
	assign fire = !empty && (!out_valid_q || segments.ready);
	assign pop  = fire && done;

	assign segments.valid = out_valid_q;
	assign segments.data  = out_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.led_level      <= seg_level;
			out_q.duration_ticks <= seg_dur;
			out_q.last_segment   <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= PH_FIRST;
			bit_cnt_q   <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				phase_q     <= nxt_phase;
				if (done) begin
					bit_cnt_q <= '0;
				end else if (cur_phase == PH_BIT_HI) begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
				end
			end else if (segments.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/led_pulse_width_bit_encoder.sv
// Channel    Dir  Payload                                      Transaction
// bytes      in   data_byte[7:0], last_byte                    one message byte
// segments   out  led_level, duration_ticks[19:0], last_segment one LED segment
// cfg        in   cfg_we, cfg_index[1:0], cfg_wdata[15:0]      one register write
//
// The back end sends one segment per cycle unless the queue is empty or output
// stalls: eight sent bits give 16 segments, the start mark 1, the end mark 3.
// The front end classifies a byte in the cycle it arrives and takes one byte per
// cycle while the command queue (QUEUE_DEPTH entries) has room.
// Reset clears message state, the queue and the output valid flag; registers
// return to their defaults. Output stalls back up only through the queue.
module led_pulse_width_bit_encoder #(
	parameter int unsigned QUEUE_DEPTH = lpwbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lpwbe_stream_if.sink                      bytes,
	lpwbe_stream_if.source                    segments,
	input  logic                              cfg_we,
	input  logic [lpwbe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lpwbe_pkg::CFG_W-1:0]       cfg_wdata
);

	lpwbe_pkg::cfg_t cfg_q;
	lpwbe_pkg::cmd_t push_cmd;
	lpwbe_pkg::cmd_t head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_ticks        <= lpwbe_pkg::UNIT_TICKS_RST;
			cfg_q.start_extra_ticks <= lpwbe_pkg::START_EXTRA_TICKS_RST;
			cfg_q.frame_limit_bits  <= lpwbe_pkg::FRAME_LIMIT_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lpwbe_pkg::CFG_UNIT_TICKS:        cfg_q.unit_ticks        <= cfg_wdata;
				lpwbe_pkg::CFG_START_EXTRA_TICKS: cfg_q.start_extra_ticks <= cfg_wdata;
				lpwbe_pkg::CFG_FRAME_LIMIT_BITS:  cfg_q.frame_limit_bits  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	lpwbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.bytes    (bytes),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lpwbe_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	lpwbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.segments (segments)
	);

endmodule

>>> bench/led_pulse_width_bit_encoder_tb.sv
module led_pulse_width_bit_encoder_tb;

	import lpwbe_pkg::*;

	localparam int unsigned END_HIGH_UNITS  = 9;
	localparam int unsigned SETTLE_CYCLES   = 64;
	localparam int unsigned WATCHDOG_LIMIT  = 4000;
	localparam int unsigned RANDOM_PHASES   = 7;
	localparam int unsigned PHASE_BYTES     = 55;

	logic clk;
	logic arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	lpwbe_stream_if #(.payload_t(byte_item_t)) byte_ch ();
	lpwbe_stream_if #(.payload_t(seg_item_t))  seg_ch ();

	led_pulse_width_bit_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.segments  (seg_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the block's registers and message state
	logic [CFG_W-1:0] unit_q;
	logic [CFG_W-1:0] start_extra_q;
	logic [CFG_W-1:0] frame_limit_q;
	logic             msg_open;
	logic [15:0]      bit_count;

	byte_item_t pending_bytes[$];
	seg_item_t  expected_segs[$];
	byte_item_t cur_byte;
	seg_item_t  want_seg;
	seg_item_t  got_seg;

	bit offering;
	bit idle_on;
	int send_gap;
	int stall_left;
	int quiet_cycles;
	int error_count;
	int bytes_sent;
	int segs_seen;
	int msgs_closed;
	int cfg_settings;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic predict_segments(input byte_item_t it);
		seg_item_t        segs[$];
		logic [DUR_W-1:0] unit_d;
		int               b;
		unit_d = DUR_W'(unit_q);
		if (!msg_open) begin
			segs.push_back('{1'b1, unit_d + DUR_W'(start_extra_q), 1'b0});
			msg_open  = 1'b1;
			bit_count = '0;
		end
		for (b = 7; b >= 0; b--) begin
			// past the frame limit a bit produces nothing
			if (bit_count < frame_limit_q) begin
				segs.push_back('{1'b0, unit_d, 1'b0});
				segs.push_back('{1'b1, it.data_byte[b] ? (unit_d << 1) : unit_d, 1'b0});
				if (bit_count != 16'hFFFF)
					bit_count++;
			end
		end
		if (it.last_byte) begin
			segs.push_back('{1'b0, unit_d, 1'b0});
			segs.push_back('{1'b1, DUR_W'(unit_d * END_HIGH_UNITS), 1'b0});
			segs.push_back('{1'b0, DUR_W'(0), 1'b0});
			msg_open  = 1'b0;
			bit_count = '0;
			msgs_closed++;
		end
		if (segs.size() > 0)
			segs[segs.size()-1].last_segment = 1'b1;
		foreach (segs[i])
			expected_segs.push_back(segs[i]);
	endtask

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data  <= '0;
			offering = 1'b0;
			send_gap = 0;
		end else begin
			if (offering && byte_ch.ready) begin
				predict_segments(cur_byte);
				bytes_sent++;
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_bytes.size() > 0) begin
					if (idle_on && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(0, 17);
					end else begin
						cur_byte = pending_bytes.pop_front();
						offering = 1'b1;
					end
				end
			end
			byte_ch.valid <= offering;
			byte_ch.data  <= cur_byte;
		end
	end

	// segment monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			seg_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (seg_ch.valid && seg_ch.ready) begin
				got_seg = seg_ch.data;
				segs_seen++;
				if (expected_segs.size() == 0) begin
					$display("%0t: unexpected segment level %0b dur %0d last %0b",
						$time, got_seg.led_level, got_seg.duration_ticks, got_seg.last_segment);
					error_count++;
				end else begin
					want_seg = expected_segs.pop_front();
					if (got_seg.led_level !== want_seg.led_level ||
						got_seg.duration_ticks !== want_seg.duration_ticks ||
						got_seg.last_segment !== want_seg.last_segment) begin
						$display("%0t: segment mismatch: expected level %0b dur %0d last %0b, got level %0b dur %0d last %0b",
							$time, want_seg.led_level, want_seg.duration_ticks,
							want_seg.last_segment, got_seg.led_level,
							got_seg.duration_ticks, got_seg.last_segment);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				seg_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 17);
				seg_ch.ready <= 1'b0;
			end else begin
				seg_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (seg_ch.valid && seg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: no transaction for %0d cycles, %0d segments still expected",
			$time, WATCHDOG_LIMIT, expected_segs.size());
		$display("led_pulse_width_bit_encoder test failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_UNIT_TICKS:        unit_q = val;
			CFG_START_EXTRA_TICKS: start_extra_q = val;
			CFG_FRAME_LIMIT_BITS:  frame_limit_q = val;
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] unit, input logic [CFG_W-1:0] extra,
		input logic [CFG_W-1:0] limit);
		write_reg(CFG_UNIT_TICKS, unit);
		write_reg(CFG_START_EXTRA_TICKS, extra);
		write_reg(CFG_FRAME_LIMIT_BITS, limit);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_settings++;
		@(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] d, input logic last);
		pending_bytes.push_back('{d, last});
	endtask

	// a dropped byte leaves nothing to wait for, so allow extra cycles after the drain
	task automatic drain();
		while (pending_bytes.size() > 0 || offering || expected_segs.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic add_random_message(output int added);
		int len;
		int i;
		logic [7:0] d;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
		for (i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0:       d = 8'h00;
				1:       d = 8'hFF;
				default: d = 8'($urandom);
			endcase
			// now and then the last flag goes missing and the message runs on
			add_byte(d, (i == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0);
		end
		added = len;
	endtask

	function automatic logic [CFG_W-1:0] pick_value(input logic [CFG_W-1:0] lo,
		input logic [CFG_W-1:0] typ_hi);
		case ($urandom_range(0, 7))
			0:       return lo;
			1:       return 16'hFFFF;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(lo, typ_hi));
		endcase
	endfunction

	initial begin
		int p;
		int n;
		int added;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data  = '0;
		seg_ch.ready  = 1'b0;
		unit_q        = UNIT_TICKS_RST;
		start_extra_q = START_EXTRA_TICKS_RST;
		frame_limit_q = FRAME_LIMIT_BITS_RST;
		msg_open      = 1'b0;
		bit_count     = '0;
		idle_on       = 1'b1;
		quiet_cycles  = 0;
		error_count   = 0;
		bytes_sent    = 0;
		segs_seen     = 0;
		msgs_closed   = 0;
		cfg_settings  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'h01, 1'b1);
		drain();
		// largest durations
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h80, 1'b1);
		drain();
		// zero unit
		apply_config(16'd0, 16'd0, 16'hFFFF);
		add_byte(8'h96, 1'b1);
		drain();
		// frame limit 0: start mark alone, then nothing, then end mark alone
		apply_config(16'd1, 16'd0, 16'd0);
		add_byte(8'hC3, 1'b0);
		add_byte(8'h3C, 1'b0);
		add_byte(8'hFF, 1'b1);
		drain();
		// limit falls inside a byte, next byte fully dropped
		apply_config(16'd3, 16'd5, 16'd3);
		add_byte(8'hE0, 1'b0);
		add_byte(8'h55, 1'b0);
		add_byte(8'h7E, 1'b1);
		drain();
		apply_config(16'd20, 16'd1, 16'd8);
		add_byte(8'h81, 1'b0);
		add_byte(8'h42, 1'b1);
		drain();
		// registers rewritten with a message open
		apply_config(16'd5, 16'd2, 16'hFFFF);
		add_byte(8'h69, 1'b0);
		drain();
		apply_config(16'd11, 16'd7, 16'd12);
		add_byte(8'h96, 1'b0);
		add_byte(8'hF0, 1'b1);
		drain();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = (p != 3);
			apply_config(pick_value(16'd1, 16'd300), pick_value(16'd0, 16'd50),
				($urandom_range(0, 2) == 0) ? 16'hFFFF : pick_value(16'd0, 16'd40));
			n = 0;
			while (n < PHASE_BYTES) begin
				add_random_message(added);
				n += added;
			end
			drain();
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		apply_config(16'd1, 16'd0, 16'hFFFF);
		n = 0;
		while (n < 40) begin
			add_random_message(added);
			n += added;
		end
		add_byte(8'h00, 1'b1);
		add_byte(8'hA5, 1'b1);
		drain();

		$display("%0d bytes in %0d closed messages, %0d segments checked, %0d register settings",
			bytes_sent, msgs_closed, segs_seen, cfg_settings);
		if (expected_segs.size() > 0) begin
			$display("%0t: %0d segments never arrived", $time, expected_segs.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("led_pulse_width_bit_encoder test passed");
		end else begin
			$display("%0d errors", error_count);
			$display("led_pulse_width_bit_encoder test failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/lpwbe_pkg.sv
rtl/core/lpwbe_stream_if.sv
rtl/core/lpwbe_front.sv
rtl/core/lpwbe_cmd_queue.sv
rtl/core/lpwbe_back.sv
rtl/core/led_pulse_width_bit_encoder.sv
bench/led_pulse_width_bit_encoder_tb.sv
